// ===== rtl/trimmed_blur_3x3_rgb_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Trimmed blur assertion macros
// Shared concurrent assertion forms for the trimmed 3x3 blur checkers.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_BLUR_3X3_RGB_UNIT_DEFINES_SVH
`define TRIMMED_BLUR_3X3_RGB_UNIT_DEFINES_SVH

// Overlapping implication, checked on every clock edge outside reset.
`define TRB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication into the next cycle, checked outside reset.
`define TRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/trb_pkg.sv =====
// ----------------------------------------------------------------------------
// Trimmed blur package
// Pixel type, sizes and arithmetic helpers shared by the trimmed blur files.
// ----------------------------------------------------------------------------
`default_nettype none

package trb_pkg;

	// Largest supported image side and the widths that follow from it.
	localparam int MAX_SIZE = 1024;
	localparam int COL_W    = $clog2(MAX_SIZE);
	localparam int CFG_W    = 11;
	localparam int MIN_SIZE = 3;

	// Window geometry.
	localparam int WIN_N = 9;

	// Channel sum over nine pixels, and intensity of one pixel.
	localparam int SUM_W = 12;
	localparam int INT_W = 10;

	// Division by seven: multiply by a scaled reciprocal and shift.
	localparam logic [12:0] DIV7_MUL   = 13'd4682;
	localparam int          DIV7_SHIFT = 15;
	localparam logic [9:0]  CHAN_MAX   = 10'd255;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// One line store entry holds the upper row and the middle row of a column.
	typedef struct packed {
		pixel_t top;
		pixel_t mid;
	} line_word_t;

	// Intensity is the plain sum of the three channels.
	function automatic logic [INT_W-1:0] intensity(input pixel_t px);
		return INT_W'(px.red) + INT_W'(px.green) + INT_W'(px.blue);
	endfunction

	// Truncating division by seven, exact for values below 4096, then clamped.
	function automatic logic [7:0] div7_clamp(input logic [SUM_W-1:0] x);
		logic [SUM_W+12:0] prod;
		logic [9:0]        quot;
		prod = (SUM_W+13)'(x) * (SUM_W+13)'(DIV7_MUL);
		quot = prod[DIV7_SHIFT+9:DIV7_SHIFT];
		return (quot > CHAN_MAX) ? 8'hFF : quot[7:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/trb_line_ram.sv =====
// ----------------------------------------------------------------------------
// Trimmed blur line RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module trb_line_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      wr_en,
	input  wire  [$clog2(DEPTH)-1:0] wr_addr,
	input  wire  [WIDTH-1:0]         wr_data,
	input  wire                      rd_en,
	input  wire  [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next enabled read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/trb_trim_core.sv =====
// ----------------------------------------------------------------------------
// Trimmed blur core
// Trimmed mean of a 3x3 window in two registered stages with a valid/ready
// handshake on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module trb_trim_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  win_valid,
	output logic                 win_ready,
	input  trb_pkg::pixel_t      win [trb_pkg::WIN_N],
	input  wire                  win_last,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [7:0]           out_red,
	output logic [7:0]           out_green,
	output logic [7:0]           out_blue,
	output logic                 frame_last
);

	import trb_pkg::*;

	logic               v_s3;
	logic               last_s3;
	logic [SUM_W-1:0]   sum_r_s3;
	logic [SUM_W-1:0]   sum_g_s3;
	logic [SUM_W-1:0]   sum_b_s3;
	pixel_t             min_px_s3;
	pixel_t             max_px_s3;

	logic               en_out;
	logic               en_s3;

	logic [SUM_W-1:0]   sum_r;
	logic [SUM_W-1:0]   sum_g;
	logic [SUM_W-1:0]   sum_b;
	pixel_t             min_px;
	pixel_t             max_px;

	// Each stage moves when the stage after it is empty or moving.
	assign en_out    = !out_valid || out_ready;
	assign en_s3     = !v_s3 || en_out;
	assign win_ready = en_s3;

	// Row-major scan: the last minimum and the first maximum win on ties.
	always_comb begin
		logic [INT_W-1:0] min_v;
		logic [INT_W-1:0] max_v;
		logic [INT_W-1:0] cur_v;
		min_v  = intensity(win[0]);
		max_v  = min_v;
		min_px = win[0];
		max_px = win[0];
		for (int i = 1; i < WIN_N; i++) begin
			cur_v = intensity(win[i]);
			if (cur_v <= min_v) begin
				min_v  = cur_v;
				min_px = win[i];
			end
			if (cur_v > max_v) begin
				max_v  = cur_v;
				max_px = win[i];
			end
		end
	end

	// Channel sums over the whole window.
	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int i = 0; i < WIN_N; i++) begin
			sum_r = sum_r + SUM_W'(win[i].red);
			sum_g = sum_g + SUM_W'(win[i].green);
			sum_b = sum_b + SUM_W'(win[i].blue);
		end
	end

	// Scan stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= win_valid;
		end
	end

	// Scan stage payload.
	always_ff @(posedge clk) begin
		if (en_s3 && win_valid) begin
			last_s3   <= win_last;
			sum_r_s3  <= sum_r;
			sum_g_s3  <= sum_g;
			sum_b_s3  <= sum_b;
			min_px_s3 <= min_px;
			max_px_s3 <= max_px;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= v_s3;
		end
	end

	// Remove the two extreme pixels, divide by seven and clamp.
	always_ff @(posedge clk) begin
		if (en_out && v_s3) begin
			out_red    <= div7_clamp(sum_r_s3 - SUM_W'(min_px_s3.red)
				- SUM_W'(max_px_s3.red));
			out_green  <= div7_clamp(sum_g_s3 - SUM_W'(min_px_s3.green)
				- SUM_W'(max_px_s3.green));
			out_blue   <= div7_clamp(sum_b_s3 - SUM_W'(min_px_s3.blue)
				- SUM_W'(max_px_s3.blue));
			frame_last <= last_s3;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/trimmed_blur_3x3_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// Trimmed 3x3 RGB blur
// Line-buffered 3x3 trimmed-mean filter over a square RGB image in raster order.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while not stalled and, once its output is
// flowing, gives one word per clock for every interior pixel; border pixels
// (first two rows and first two columns of the newest-pixel position) give no
// word. A result word leaves through the line RAM read, the window register, the
// min/max scan and sum register, and the output register, after the pixel that
// completes its window is taken. The rate is set by the line RAM, which does one
// read and one write of a two-row column entry in each cycle. Writing the size
// register restarts the frame at row 0, column 0; sizes below 3 act as 3 and
// sizes above 1024 act as 1024. The line RAM needs no clearing after reset.
`default_nettype none

module trimmed_blur_3x3_rgb_unit (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_wr_en,
	input  wire  [trb_pkg::CFG_W-1:0]  cfg_wr_data,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire  [7:0]                 red,
	input  wire  [7:0]                 green,
	input  wire  [7:0]                 blue,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [7:0]                 out_red,
	output logic [7:0]                 out_green,
	output logic [7:0]                 out_blue,
	output logic                       frame_last
);

	import trb_pkg::*;

	logic [COL_W-1:0]  size_m1_q;
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  row_q;
	logic [COL_W-1:0]  cfg_size_m1;

	logic              in_acc;
	logic              adv_s1;
	logic              win_ready;

	logic              v_s1;
	pixel_t            px_s1;
	logic [COL_W-1:0]  col_s1;
	logic              prod_s1;
	logic              last_s1;
	line_word_t        rd_word;
	line_word_t        wr_word;

	logic              v_s2;
	logic              last_s2;
	pixel_t            win_s2 [WIN_N];

	// Clamp the written size into the supported range.
	always_comb begin
		if (int'(cfg_wr_data) < MIN_SIZE) begin
			cfg_size_m1 = COL_W'(MIN_SIZE - 1);
		end else if (int'(cfg_wr_data) > MAX_SIZE) begin
			cfg_size_m1 = COL_W'(MAX_SIZE - 1);
		end else begin
			cfg_size_m1 = COL_W'(int'(cfg_wr_data) - 1);
		end
	end

	// The first stage drains into the window when the window is free.
	assign adv_s1   = v_s1 && (!v_s2 || win_ready);
	assign in_ready = !v_s1 || !v_s2 || win_ready;
	assign in_acc   = in_valid && in_ready;

	// Size register and raster position of the next pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_m1_q <= COL_W'(MAX_SIZE - 1);
			col_q     <= '0;
			row_q     <= '0;
		end else if (cfg_wr_en) begin
			size_m1_q <= cfg_size_m1;
			col_q     <= '0;
			row_q     <= '0;
		end else if (in_acc) begin
			if (col_q == size_m1_q) begin
				col_q <= '0;
				row_q <= (row_q == size_m1_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// First stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	// First stage payload, alongside the line RAM read.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1   <= '{blue: blue, green: green, red: red};
			col_s1  <= col_q;
			prod_s1 <= (row_q >= COL_W'(2)) && (col_q >= COL_W'(2));
			last_s1 <= (row_q == size_m1_q) && (col_q == size_m1_q);
		end
	end

	// Shift the rows up one place in the column entry.
	assign wr_word = '{top: rd_word.mid, mid: px_s1};

	trb_line_ram #(
		.WIDTH($bits(line_word_t)),
		.DEPTH(MAX_SIZE)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (wr_word),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (rd_word)
	);

	// Window stage control: only interior pixels go on to the core.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= prod_s1;
		end else if (win_ready) begin
			v_s2 <= 1'b0;
		end
	end

	// Window shifts left by one column for every pixel, border or not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_N; i++) begin
				win_s2[i] <= '0;
			end
			last_s2 <= 1'b0;
		end else if (adv_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_s2[r*3]     <= win_s2[r*3 + 1];
				win_s2[r*3 + 1] <= win_s2[r*3 + 2];
			end
			win_s2[2] <= rd_word.top;
			win_s2[5] <= rd_word.mid;
			win_s2[8] <= px_s1;
			last_s2   <= last_s1;
		end
	end

	trb_trim_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.win_valid  (v_s2),
		.win_ready  (win_ready),
		.win        (win_s2),
		.win_last   (last_s2),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.frame_last (frame_last)
	);

endmodule

`default_nettype wire

// ===== rtl/trb_checker.sv =====
// ----------------------------------------------------------------------------
// Trimmed blur checker
// Port-level assertions for the trimmed 3x3 blur, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trimmed_blur_3x3_rgb_unit_defines.svh"

module trb_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire  [7:0] out_red,
	input wire  [7:0] out_green,
	input wire  [7:0] out_blue,
	input wire        frame_last
);

	// A stalled result word holds still.
	`TRB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(frame_last), "result word changed while stalled")

	// With the output free the whole pipeline moves, so the input is ready.
	`TRB_ASSERT_SAME(a_in_free, clk, arst_n, !out_valid || out_ready, in_ready, "input stalled while output was free")

	// A fresh result word follows a pixel taken at the input.
	`TRB_ASSERT_SAME(a_out_origin, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 4), "result word without a matching pixel")

endmodule

bind trimmed_blur_3x3_rgb_unit trb_checker u_trb_checker (.*);

`default_nettype wire

// ===== verif/trimmed_blur_3x3_rgb_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Trimmed blur checker
// Watches the pixel, result and size ports of the trimmed 3x3 blur, keeps its
// own line rows and window, predicts each filtered word and compares it.
// ----------------------------------------------------------------------------
module trimmed_blur_3x3_rgb_checker (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_wr_en,
	input  wire [trb_pkg::CFG_W-1:0]  cfg_wr_data,
	input  wire                       in_valid,
	input  wire                       in_ready,
	input  wire [7:0]                 red,
	input  wire [7:0]                 green,
	input  wire [7:0]                 blue,
	input  wire                       out_valid,
	input  wire                       out_ready,
	input  wire [7:0]                 out_red,
	input  wire [7:0]                 out_green,
	input  wire [7:0]                 out_blue,
	input  wire                       frame_last,
	output int                        fail_count,
	output int                        pending
);
	import trb_pkg::*;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} blur_word_t;

	// Predicted image state: two previous rows, the window and the raster position.
	pixel_t     upper_row [MAX_SIZE];
	pixel_t     middle_row [MAX_SIZE];
	pixel_t     win [3][3];
	int         side_reg;
	int         col_pos;
	int         row_pos;
	int         mismatches;
	int         slot;
	blur_word_t filtered_words [$];
	blur_word_t head;

	function automatic int brightness(input pixel_t px);
		return int'(px.red) + int'(px.green) + int'(px.blue);
	endfunction

	function automatic logic [7:0] trim_channel(input int total);
		int q;
		q = total / 7;
		if (q > 255)
			q = 255;
		return 8'(q);
	endfunction

	// Drop the darkest (last on ties) and brightest (first on ties) pixel of
	// the window and average the remaining seven per channel.
	function automatic blur_word_t trimmed_mean();
		pixel_t     flat [9];
		int         i;
		int         lum;
		int         lo_val;
		int         hi_val;
		int         lo_idx;
		int         hi_idx;
		int         sum_r;
		int         sum_g;
		int         sum_b;
		blur_word_t w;
		for (i = 0; i < 9; i++)
			flat[i] = win[i / 3][i % 3];
		lo_val = brightness(flat[0]);
		hi_val = lo_val;
		lo_idx = 0;
		hi_idx = 0;
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		for (i = 1; i < 9; i++) begin
			lum = brightness(flat[i]);
			if (lum <= lo_val) begin
				lo_val = lum;
				lo_idx = i;
			end
			if (lum > hi_val) begin
				hi_val = lum;
				hi_idx = i;
			end
		end
		for (i = 0; i < 9; i++) begin
			sum_r += flat[i].red;
			sum_g += flat[i].green;
			sum_b += flat[i].blue;
		end
		sum_r -= flat[lo_idx].red + flat[hi_idx].red;
		sum_g -= flat[lo_idx].green + flat[hi_idx].green;
		sum_b -= flat[lo_idx].blue + flat[hi_idx].blue;
		w.red   = trim_channel(sum_r);
		w.green = trim_channel(sum_g);
		w.blue  = trim_channel(sum_b);
		w.last  = 1'b0;
		return w;
	endfunction

	// Advance the line rows and the window by one pixel, and queue a word for
	// every interior position.
	task automatic take_pixel(input pixel_t px);
		int         side;
		int         col;
		int         row;
		int         r;
		pixel_t     above;
		pixel_t     middle;
		blur_word_t w;
		side = (side_reg < MIN_SIZE) ? MIN_SIZE : (side_reg > MAX_SIZE) ? MAX_SIZE : side_reg;
		col = (col_pos >= side) ? 0 : col_pos;
		row = (row_pos >= side) ? 0 : row_pos;
		above = upper_row[col];
		middle = middle_row[col];
		upper_row[col] = middle;
		middle_row[col] = px;
		for (r = 0; r < 3; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = above;
		win[1][2] = middle;
		win[2][2] = px;
		if (row >= 2 && col >= 2) begin
			w = trimmed_mean();
			w.last = (row == side - 1) && (col == side - 1);
			filtered_words.push_back(w);
		end
		col++;
		if (col >= side) begin
			col = 0;
			row++;
			if (row >= side)
				row = 0;
		end
		col_pos = col;
		row_pos = row;
	endtask

	// Compare one accepted result word with the oldest prediction.
	task automatic check_word();
		if (filtered_words.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected word r=%0d g=%0d b=%0d last=%0b", $time,
					out_red, out_green, out_blue, frame_last);
		end else begin
			head = filtered_words.pop_front();
			if (out_red !== head.red || out_green !== head.green ||
				out_blue !== head.blue || frame_last !== head.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: word mismatch: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
						$time, head.red, head.green, head.blue, head.last,
						out_red, out_green, out_blue, frame_last);
			end
		end
	endtask

	// Track size writes, pixels and result words on every edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (slot = 0; slot < MAX_SIZE; slot++) begin
				upper_row[slot] = '0;
				middle_row[slot] = '0;
			end
			for (slot = 0; slot < 9; slot++)
				win[slot / 3][slot % 3] = '0;
			side_reg = MAX_SIZE;
			col_pos = 0;
			row_pos = 0;
			mismatches = 0;
			filtered_words.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				side_reg = int'(cfg_wr_data);
				col_pos = 0;
				row_pos = 0;
			end
			if (in_valid && in_ready)
				take_pixel(pixel_t'({blue, green, red}));
			if (out_valid && out_ready)
				check_word();
			fail_count <= mismatches;
			pending <= filtered_words.size();
		end
	end

endmodule

// ===== verif/tb_trimmed_blur_3x3_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// Trimmed 3x3 RGB blur testbench
// Streams directed and random images of many sizes through the blur with
// random gaps on both sides; a checker beside the unit predicts every word.
// ----------------------------------------------------------------------------
module tb_trimmed_blur_3x3_rgb_unit;
	import trb_pkg::*;

	typedef enum int {
		FILL_RANDOM,
		FILL_TIES,
		FILL_EXTREMES,
		FILL_FLAT
	} fill_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_W-1:0]     cfg_wr_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic                 out_valid;
	logic                 out_ready;
	logic [7:0]           out_red;
	logic [7:0]           out_green;
	logic [7:0]           out_blue;
	logic                 frame_last;
	int                   fail_count;
	int                   pending;
	bit                   steady;

	// Clock with a period of ten units.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	trimmed_blur_3x3_rgb_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.frame_last  (frame_last)
	);

	trimmed_blur_3x3_rgb_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.frame_last  (frame_last),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	function automatic pixel_t make_pixel(input fill_t fill, input pixel_t base);
		pixel_t px;
		case (fill)
			FILL_RANDOM: begin
				px.red   = 8'($urandom);
				px.green = 8'($urandom);
				px.blue  = 8'($urandom);
			end
			FILL_TIES: begin
				px.red   = 8'($urandom_range(0, 3));
				px.green = 8'($urandom_range(0, 3));
				px.blue  = 8'($urandom_range(0, 3));
			end
			FILL_EXTREMES: begin
				px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			default: begin
				px = base;
				if ($urandom_range(0, 3) == 0)
					px = make_pixel(FILL_RANDOM, base);
			end
		endcase
		return px;
	endfunction

	// Offer one pixel word, after an optional gap, and hold it until taken.
	task automatic send_pixel(input pixel_t px);
		int gap;
		gap = steady ? 0 : idle_cycles();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		red      <= px.red;
		green    <= px.green;
		blue     <= px.blue;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Write the image size once the unit has drained; pixels that give no
	// word may still be in the pipeline, so allow its depth to pass as well.
	task automatic set_size(input int side);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= CFG_W'(side);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_image(input int count, input fill_t fill);
		pixel_t base;
		base = make_pixel(FILL_RANDOM, base);
		repeat (count) send_pixel(make_pixel(fill, base));
	endtask

	// Result side stalls: bursts of ready with short or long breaks, and
	// sometimes a long stretch with no stall at all.
	initial begin
		int run;
		int hold;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
			hold = idle_cycles();
			@(negedge clk);
			out_ready <= 1'b1;
			repeat (run - 1) @(negedge clk);
			if (hold > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end
		end
	end

	// Main stimulus and verdict.
	initial begin
		int    i;
		int    side;
		int    eff;
		int    count;
		int    pick;
		int    random_sent;
		fill_t fill;
		pixel_t px;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		red         = '0;
		green       = '0;
		blue        = '0;
		steady      = 1'b0;
		random_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Smallest image, every channel at full scale.
		set_size(MIN_SIZE);
		for (i = 0; i < 9; i++)
			send_pixel(pixel_t'({8'hFF, 8'hFF, 8'hFF}));

		// Equal intensity everywhere: the last pixel is the minimum and the
		// first one the maximum.
		for (i = 0; i < 9; i++) begin
			px.red   = 8'(i * 10);
			px.green = 8'd100;
			px.blue  = 8'(200 - i * 10);
			send_pixel(px);
		end

		// A size below the minimum acts as three; channels at both extremes.
		set_size(0);
		for (i = 0; i < 9; i++) begin
			px.red   = i[0] ? 8'hFF : 8'h00;
			px.green = i[1] ? 8'hFF : 8'h00;
			px.blue  = i[2] ? 8'hFF : 8'h00;
			send_pixel(px);
		end

		// Random images: whole frames back to back, and partial frames cut
		// short by the next size write.
		while (random_sent < 820) begin
			pick = $urandom_range(0, 99);
			if (pick < 5)
				side = $urandom_range(0, 2);
			else if (pick < 75)
				side = $urandom_range(3, 8);
			else
				side = $urandom_range(9, 20);
			eff = (side < MIN_SIZE) ? MIN_SIZE : side;
			if ($urandom_range(0, 9) < 6)
				count = eff * eff * ((eff > 12) ? 1 : $urandom_range(1, 3));
			else
				count = $urandom_range(1, 2 * eff * eff);
			fill = fill_t'($urandom_range(0, 3));
			steady = ($urandom_range(0, 3) == 0);
			set_size(side);
			send_image(count, fill);
			random_sent += count;
		end

		// Largest image, written directly and as an oversized value: a stretch
		// of the top row, which gives no word.
		steady = 1'b0;
		set_size(MAX_SIZE);
		send_image(40, FILL_RANDOM);
		set_size(2047);
		send_image(40, FILL_TIES);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin
		#15000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== trimmed_blur_3x3_rgb_unit.f =====
+incdir+rtl
rtl/trb_pkg.sv
rtl/trb_line_ram.sv
rtl/trb_trim_core.sv
rtl/trimmed_blur_3x3_rgb_unit.sv
rtl/trb_checker.sv
verif/trimmed_blur_3x3_rgb_unit_checker.sv
verif/tb_trimmed_blur_3x3_rgb_unit.sv
